### sv/fcwe_pkg.sv
`default_nettype none

package fcwe_pkg;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_STATUS_RD   = 3'd1,
    MODE_DATA_RD     = 3'd2,
    MODE_CMD_WR      = 3'd3,
    MODE_DATA_WR     = 3'd4
  } mode_t;

  localparam int unsigned MAX_DRIVES = 4;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  localparam logic [15:0] ST_TRK0  = 16'h0001;
  localparam logic [15:0] ST_READY = 16'h0002;
  localparam logic [15:0] ST_WP    = 16'h0004;
  localparam logic [15:0] ST_MORE  = 16'h0080;
  localparam logic [15:0] ST_CRC   = 16'h4000;
  localparam logic [15:0] ST_INDEX = 16'h8000;

  // command register bits
  localparam int unsigned CMD_MOTOR  = 4;
  localparam int unsigned CMD_SIDE   = 5;
  localparam int unsigned CMD_DIR    = 6;
  localparam int unsigned CMD_STEP   = 7;
  localparam int unsigned CMD_SEARCH = 8;
  localparam int unsigned CMD_MARK   = 9;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc_shift8(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/floppy_controller_word_engine_unit.sv
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle; the result register is the only stage,
// and a new request is taken whenever it is empty or being drained.
// Reset (rst, synchronous, active high) clears all controller state,
// presets the running CRC to 0xFFFF and sets drive_count to 4.
`default_nettype none

module floppy_controller_word_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data,          // drive_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // write_value[15:0], first_byte[23:16], second_byte[31:24], mark_under_head[32],
  // disk_loaded[33], write_protected[34], at_track_zero[35], at_index[36], zero[39:37]
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,      // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_word[15:0], disk_write_valid[16], disk_first_byte[24:17],
  // disk_second_byte[32:25], disk_write_mark[33], drive_select[35:34],
  // side_select[36], motor_enable[37], step_pulse[38], step_inward[39]
  output logic [39:0]      m_axis_tdata
);
  import fcwe_pkg::*;

  logic [2:0]  drive_count;
  logic [15:0] command_word, command_word_next;
  logic        drive_selected, drive_selected_next;
  logic [1:0]  drive_number, drive_number_next;
  logic        side_bit, side_bit_next;
  logic        more_data, more_data_next;
  logic        crc_good, crc_good_next;
  logic [15:0] data_latch, data_latch_next;
  logic [15:0] write_holding, write_holding_next;
  logic [15:0] shift_word, shift_word_next;
  logic        holding_full, holding_full_next;
  logic        shift_full, shift_full_next;
  logic        holding_is_mark, holding_is_mark_next;
  logic        shift_is_mark, shift_is_mark_next;
  logic        write_mode, write_mode_next;
  logic        search_armed, search_armed_next;
  logic        mark_search, mark_search_next;
  logic        crc_active, crc_active_next;
  logic [15:0] running_crc, running_crc_next;

  logic [15:0] write_value;
  logic [7:0]  first_byte, second_byte;
  logic        mark_under_head, disk_loaded, write_protected, at_track_zero, at_index;
  mode_t       mode;

  logic [15:0] rd;
  logic [7:0]  wlo, whi;
  logic        wvalid, wmark, step;
  logic [2:0]  drive_limit;
  logic        present_cur, present_new;
  logic [15:0] crc_tmp;
  logic        accept;
  logic [39:0] result;

  assign cfg_ready     = !rst;
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign write_value     = s_axis_tdata[15:0];
  assign first_byte      = s_axis_tdata[23:16];
  assign second_byte     = s_axis_tdata[31:24];
  assign mark_under_head = s_axis_tdata[32];
  assign disk_loaded     = s_axis_tdata[33];
  assign write_protected = s_axis_tdata[34];
  assign at_track_zero   = s_axis_tdata[35];
  assign at_index        = s_axis_tdata[36];
  assign mode            = mode_t'(s_axis_tuser);

  assign drive_limit = (drive_count > 3'(MAX_DRIVES)) ? 3'(MAX_DRIVES) : drive_count;
  assign present_cur = drive_selected && ({1'b0, drive_number} < drive_limit);

  always_comb begin
    command_word_next    = command_word;
    drive_selected_next  = drive_selected;
    drive_number_next    = drive_number;
    side_bit_next        = side_bit;
    more_data_next       = more_data;
    crc_good_next        = crc_good;
    data_latch_next      = data_latch;
    write_holding_next   = write_holding;
    shift_word_next      = shift_word;
    holding_full_next    = holding_full;
    shift_full_next      = shift_full;
    holding_is_mark_next = holding_is_mark;
    shift_is_mark_next   = shift_is_mark;
    write_mode_next      = write_mode;
    search_armed_next    = search_armed;
    mark_search_next     = mark_search;
    crc_active_next      = crc_active;
    running_crc_next     = running_crc;
    rd                   = '0;
    wlo                  = '0;
    whi                  = '0;
    wvalid               = 1'b0;
    wmark                = 1'b0;
    step                 = 1'b0;
    crc_tmp              = running_crc;
    present_new          = present_cur;

    case (mode)
      MODE_TICK: begin
        if (command_word[CMD_MOTOR] && present_cur && disk_loaded) begin
          if (!write_mode) begin
            data_latch_next = {first_byte, second_byte};
            if (more_data) begin
              if (crc_active) begin
                crc_active_next = 1'b0;
                crc_good_next   = (running_crc == 16'h0000);
              end
            end else if (mark_search) begin
              if (mark_under_head) begin
                more_data_next   = 1'b1;
                mark_search_next = 1'b0;
                crc_active_next  = 1'b1;
                running_crc_next = crc_shift8(crc_shift8(CRC_PRESET, first_byte), second_byte);
              end
            end else begin
              more_data_next = 1'b1;
              if (crc_active) begin
                running_crc_next = crc_shift8(crc_shift8(running_crc, first_byte), second_byte);
              end
            end
          end else if (shift_full) begin
            wlo    = shift_word[7:0];
            whi    = shift_word[15:8];
            wvalid = 1'b1;
            wmark  = shift_is_mark;
            crc_tmp = shift_is_mark ? CRC_PRESET : running_crc;
            if (shift_is_mark || crc_active) begin
              crc_tmp = crc_shift8(crc_shift8(crc_tmp, wlo), whi);
            end
            running_crc_next   = crc_tmp;
            crc_active_next    = shift_is_mark || crc_active;
            shift_full_next    = 1'b0;
            shift_is_mark_next = 1'b0;
            if (holding_full) begin
              shift_word_next      = write_holding;
              shift_full_next      = 1'b1;
              holding_full_next    = 1'b0;
              shift_is_mark_next   = holding_is_mark;
              holding_is_mark_next = 1'b0;
              more_data_next       = 1'b1;
            end else if (shift_is_mark || crc_active) begin
              shift_word_next = {crc_tmp[7:0], crc_tmp[15:8]};
              shift_full_next = 1'b1;
              crc_active_next = 1'b0;
              crc_good_next   = 1'b1;
            end
          end
        end
      end
      MODE_STATUS_RD: begin
        if (!drive_selected) begin
          rd = '0;
        end else if (!present_cur) begin
          rd = ST_INDEX | ST_TRK0;
        end else begin
          rd = at_track_zero ? ST_TRK0 : 16'h0000;
          if (!disk_loaded) begin
            rd = rd | ST_INDEX;
          end else begin
            if (at_index)        rd = rd | ST_INDEX;
            if (write_protected) rd = rd | ST_WP;
            if (command_word[CMD_MOTOR]) begin
              rd = rd | ST_READY | (more_data ? ST_MORE : 16'h0000)
                 | (crc_good ? ST_CRC : 16'h0000);
            end
          end
        end
      end
      MODE_DATA_RD: begin
        more_data_next    = 1'b0;
        mark_search_next  = 1'b0;
        holding_full_next = 1'b0;
        shift_full_next   = 1'b0;
        write_mode_next   = 1'b0;
        rd = (present_cur && disk_loaded) ? data_latch : 16'h0000;
      end
      MODE_CMD_WR: begin
        command_word_next = write_value;
        drive_selected_next = |write_value[3:0];
        if (write_value[0])      drive_number_next = 2'd0;
        else if (write_value[1]) drive_number_next = 2'd1;
        else if (write_value[2]) drive_number_next = 2'd2;
        else if (write_value[3]) drive_number_next = 2'd3;
        else                     drive_number_next = 2'd0;
        present_new = drive_selected_next && ({1'b0, drive_number_next} < drive_limit);
        if (!write_value[CMD_MOTOR]) begin
          more_data_next = 1'b0;
          crc_good_next  = 1'b0;
        end
        if (drive_selected_next) begin
          side_bit_next = write_value[CMD_SIDE];
          if (write_value[CMD_STEP] && present_new) begin
            step = write_value[CMD_DIR] ? 1'b1 : !at_track_zero;
          end
          if (write_value[CMD_SEARCH]) begin
            search_armed_next = 1'b1;
          end else if (search_armed) begin
            search_armed_next = 1'b0;
            mark_search_next  = 1'b1;
            crc_active_next   = 1'b0;
            crc_good_next     = 1'b0;
            more_data_next    = 1'b0;
          end
          if (write_mode && write_value[CMD_MARK]) begin
            holding_is_mark_next = 1'b1;
            crc_good_next        = 1'b0;
            more_data_next       = 1'b0;
          end
        end
      end
      MODE_DATA_WR: begin
        write_mode_next  = 1'b1;
        mark_search_next = 1'b0;
        if (!holding_full && !shift_full) begin
          shift_word_next = write_value;
          shift_full_next = 1'b1;
          more_data_next  = 1'b1;
        end else if (!holding_full) begin
          write_holding_next = write_value;
          holding_full_next  = 1'b1;
          more_data_next     = 1'b0;
        end else if (!shift_full) begin
          shift_word_next      = write_holding;
          shift_full_next      = 1'b1;
          shift_is_mark_next   = holding_is_mark;
          holding_is_mark_next = 1'b0;
          write_holding_next   = write_value;
          holding_full_next    = 1'b1;
          more_data_next       = 1'b0;
        end else begin
          write_holding_next = write_value;
        end
      end
      default: begin
      end
    endcase

    result = {command_word_next[CMD_DIR],
              step,
              command_word_next[CMD_MOTOR] && present_new,
              side_bit_next,
              drive_selected_next ? drive_number_next : 2'd0,
              wmark, whi, wlo, wvalid, rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_count <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      drive_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_word    <= '0;
      drive_selected  <= 1'b0;
      drive_number    <= '0;
      side_bit        <= 1'b0;
      more_data       <= 1'b0;
      crc_good        <= 1'b0;
      data_latch      <= '0;
      write_holding   <= '0;
      shift_word      <= '0;
      holding_full    <= 1'b0;
      shift_full      <= 1'b0;
      holding_is_mark <= 1'b0;
      shift_is_mark   <= 1'b0;
      write_mode      <= 1'b0;
      search_armed    <= 1'b0;
      mark_search     <= 1'b0;
      crc_active      <= 1'b0;
      running_crc     <= CRC_PRESET;
    end else if (accept) begin
      command_word    <= command_word_next;
      drive_selected  <= drive_selected_next;
      drive_number    <= drive_number_next;
      side_bit        <= side_bit_next;
      more_data       <= more_data_next;
      crc_good        <= crc_good_next;
      data_latch      <= data_latch_next;
      write_holding   <= write_holding_next;
      shift_word      <= shift_word_next;
      holding_full    <= holding_full_next;
      shift_full      <= shift_full_next;
      holding_is_mark <= holding_is_mark_next;
      shift_is_mark   <= shift_is_mark_next;
      write_mode      <= write_mode_next;
      search_armed    <= search_armed_next;
      mark_search     <= mark_search_next;
      crc_active      <= crc_active_next;
      running_crc     <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= result;
    end
  end

endmodule

`default_nettype wire

### sv/fcwe_checker.sv
`default_nettype none

module fcwe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every accepted request yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // disk bytes and mark are zero unless a word is written
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[33:17] == 17'h0)
    else $error("disk write fields set without a write");

  // a disk write only happens on a tick, where no word is read
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'h0)
    else $error("read word set during disk write");

endmodule

bind floppy_controller_word_engine_unit fcwe_checker u_fcwe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb.sv
module tb;
  import fcwe_pkg::*;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam int unsigned ITEMS_PER_PHASE = 195;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned MAX_PRINTS      = 40;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] value;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        mark;
    logic        loaded;
    logic        wprot;
    logic        trk0;
    logic        index_hole;
  } ctrl_request_t;

  // same bit order as m_axis_tdata, highest field first
  typedef struct packed {
    logic        inward;
    logic        step;
    logic        motor;
    logic        side;
    logic [1:0]  drive_sel;
    logic        wr_mark;
    logic [7:0]  wr_second;
    logic [7:0]  wr_first;
    logic        wr_valid;
    logic [15:0] read_word;
  } ctrl_result_t;

  class ctrl_scoreboard;
    int unsigned  mismatches;
    int unsigned  checked;
    ctrl_result_t pending_results[$];

    logic [2:0]  drive_count;
    logic [15:0] cmd_reg;
    logic        drv_on;
    logic [1:0]  drv_num;
    logic        side_bit, more_data, crc_ok;
    logic [15:0] data_reg, hold_word, shift_reg;
    logic        hold_full, shift_full, hold_mark, shift_mark;
    logic        writing, search_armed, mark_hunt, crc_on;
    logic [15:0] crc;

    function new();
      mismatches = 0;
      checked = 0;
      drive_count = 3'(MAX_DRIVES);
      cmd_reg = '0;
      drv_on = 1'b0;
      drv_num = '0;
      side_bit = 1'b0;
      more_data = 1'b0;
      crc_ok = 1'b0;
      data_reg = '0;
      hold_word = '0;
      shift_reg = '0;
      hold_full = 1'b0;
      shift_full = 1'b0;
      hold_mark = 1'b0;
      shift_mark = 1'b0;
      writing = 1'b0;
      search_armed = 1'b0;
      mark_hunt = 1'b0;
      crc_on = 1'b0;
      crc = CRC_PRESET;
    endfunction

    // bit-serial CCITT, MSB first
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function logic drive_here();
      logic [2:0] n;
      n = (drive_count > 3'(MAX_DRIVES)) ? 3'(MAX_DRIVES) : drive_count;
      return drv_on && ({1'b0, drv_num} < n);
    endfunction

    function ctrl_result_t controller_step(ctrl_request_t r);
      ctrl_result_t res;
      logic [15:0] v;
      res = '0;
      v = r.value;
      case (r.mode)
        MODE_TICK: begin
          if (cmd_reg[CMD_MOTOR] && drive_here() && r.loaded) begin
            if (!writing) begin
              data_reg = {r.first_byte, r.second_byte};
              if (more_data) begin
                if (crc_on) begin
                  crc_on = 1'b0;
                  crc_ok = (crc == 16'h0000);
                end
              end else if (mark_hunt) begin
                if (r.mark) begin
                  more_data = 1'b1;
                  mark_hunt = 1'b0;
                  crc_on = 1'b1;
                  crc = crc_next(crc_next(CRC_PRESET, r.first_byte), r.second_byte);
                end
              end else begin
                more_data = 1'b1;
                if (crc_on) crc = crc_next(crc_next(crc, r.first_byte), r.second_byte);
              end
            end else if (shift_full) begin
              res.wr_valid = 1'b1;
              res.wr_first = shift_reg[7:0];
              res.wr_second = shift_reg[15:8];
              res.wr_mark = shift_mark;
              if (shift_mark) begin
                crc = CRC_PRESET;
                crc_on = 1'b1;
              end
              if (crc_on) crc = crc_next(crc_next(crc, shift_reg[7:0]), shift_reg[15:8]);
              shift_full = 1'b0;
              shift_mark = 1'b0;
              if (hold_full) begin
                shift_reg = hold_word;
                shift_full = 1'b1;
                hold_full = 1'b0;
                shift_mark = hold_mark;
                hold_mark = 1'b0;
                more_data = 1'b1;
              end else if (crc_on) begin
                shift_reg = {crc[7:0], crc[15:8]};
                shift_full = 1'b1;
                crc_on = 1'b0;
                crc_ok = 1'b1;
              end
            end
          end
        end
        MODE_STATUS_RD: begin
          if (!drv_on) res.read_word = '0;
          else if (!drive_here()) res.read_word = ST_INDEX | ST_TRK0;
          else begin
            res.read_word = r.trk0 ? ST_TRK0 : '0;
            if (!r.loaded) res.read_word |= ST_INDEX;
            else begin
              if (r.index_hole) res.read_word |= ST_INDEX;
              if (r.wprot) res.read_word |= ST_WP;
              if (cmd_reg[CMD_MOTOR])
                res.read_word |= ST_READY | (more_data ? ST_MORE : '0) | (crc_ok ? ST_CRC : '0);
            end
          end
        end
        MODE_DATA_RD: begin
          more_data = 1'b0;
          mark_hunt = 1'b0;
          hold_full = 1'b0;
          shift_full = 1'b0;
          writing = 1'b0;
          res.read_word = (drive_here() && r.loaded) ? data_reg : '0;
        end
        MODE_CMD_WR: begin
          cmd_reg = v;
          drv_on = (v[3:0] != 4'b0000);
          if (v[0]) drv_num = 2'd0;
          else if (v[1]) drv_num = 2'd1;
          else if (v[2]) drv_num = 2'd2;
          else if (v[3]) drv_num = 2'd3;
          else drv_num = 2'd0;
          if (!v[CMD_MOTOR]) begin
            more_data = 1'b0;
            crc_ok = 1'b0;
          end
          if (drv_on) begin
            side_bit = v[CMD_SIDE];
            if (v[CMD_STEP] && drive_here()) res.step = v[CMD_DIR] ? 1'b1 : !r.trk0;
            if (v[CMD_SEARCH]) search_armed = 1'b1;
            else if (search_armed) begin
              search_armed = 1'b0;
              mark_hunt = 1'b1;
              crc_on = 1'b0;
              crc_ok = 1'b0;
              more_data = 1'b0;
            end
            if (writing && v[CMD_MARK]) begin
              hold_mark = 1'b1;
              crc_ok = 1'b0;
              more_data = 1'b0;
            end
          end
        end
        MODE_DATA_WR: begin
          writing = 1'b1;
          mark_hunt = 1'b0;
          if (!hold_full && !shift_full) begin
            shift_reg = v;
            shift_full = 1'b1;
            more_data = 1'b1;
          end else if (!hold_full) begin
            hold_word = v;
            hold_full = 1'b1;
            more_data = 1'b0;
          end else if (!shift_full) begin
            shift_reg = hold_word;
            shift_full = 1'b1;
            shift_mark = hold_mark;
            hold_mark = 1'b0;
            hold_word = v;
            hold_full = 1'b1;
            more_data = 1'b0;
          end else begin
            hold_word = v;
          end
        end
        default: ;
      endcase
      res.drive_sel = drv_on ? drv_num : 2'd0;
      res.side = side_bit;
      res.motor = cmd_reg[CMD_MOTOR] && drive_here();
      res.inward = cmd_reg[CMD_DIR];
      return res;
    endfunction

    function void note_request(ctrl_request_t r);
      pending_results.insert(pending_results.size(), controller_step(r));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%h, want 0x%h", checked, name, got, want));
    endtask

    task check_result(ctrl_result_t got);
      ctrl_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unrequested result 0x%h", got));
      end else begin
        want = pending_results.pop_front();
        check_field("read_word", got.read_word, want.read_word);
        check_field("disk_write_valid", 16'(got.wr_valid), 16'(want.wr_valid));
        check_field("disk_first_byte", 16'(got.wr_first), 16'(want.wr_first));
        check_field("disk_second_byte", 16'(got.wr_second), 16'(want.wr_second));
        check_field("disk_write_mark", 16'(got.wr_mark), 16'(want.wr_mark));
        check_field("drive_select", 16'(got.drive_sel), 16'(want.drive_sel));
        check_field("side_select", 16'(got.side), 16'(want.side));
        check_field("motor_enable", 16'(got.motor), 16'(want.motor));
        check_field("step_pulse", 16'(got.step), 16'(want.step));
        check_field("step_inward", 16'(got.inward), 16'(want.inward));
        checked++;
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  ctrl_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  bit          hold_req = 1'b0;
  logic [2:0]  count_plan [8];

  floppy_controller_word_engine_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  task put_request(ctrl_request_t r);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= {3'b000, r.index_hole, r.trk0, r.wprot, r.loaded, r.mark,
                      r.second_byte, r.first_byte, r.value};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(r);
    sent_count++;
    burst_left--;
  endtask

  // lines = {mark, loaded, wp, trk0, index}
  task put_fixed(logic [2:0] mode, logic [15:0] value, logic [15:0] bytes, logic [4:0] lines);
    put_request(ctrl_request_t'{mode, value, bytes[15:8], bytes[7:0],
                                lines[4], lines[3], lines[2], lines[1], lines[0]});
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_drive_count(logic [2:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.drive_count = n;
  endtask

  function ctrl_request_t sense_req(logic [2:0] mode, logic [15:0] value);
    ctrl_request_t r;
    r.mode = mode;
    r.value = value;
    r.first_byte = 8'($urandom);
    r.second_byte = 8'($urandom);
    r.mark = ($urandom_range(7, 0) == 0);
    r.loaded = ($urandom_range(15, 0) != 0);
    r.wprot = 1'($urandom);
    r.trk0 = 1'($urandom);
    r.index_hole = 1'($urandom);
    return r;
  endfunction

  function logic [15:0] cmd_value(logic [1:0] drv, logic motor, logic search, logic mark);
    logic [15:0] v;
    v = 16'($urandom);
    v[3:0] = 4'b0001 << drv;
    v[CMD_MOTOR] = motor;
    v[CMD_SEARCH] = search;
    v[CMD_MARK] = mark;
    return v;
  endfunction

  task directed_checks();
    put_fixed(MODE_STATUS_RD, 16'hFFFF, 16'hFFFF, 5'b11111);
    put_fixed(MODE_DATA_RD, 16'h0000, 16'h0000, 5'b01000);
    put_fixed(MODE_TICK, 16'h0000, 16'hFF00, 5'b11000);
    // drive 3, motor, side, outward step on track zero
    put_fixed(MODE_CMD_WR, 16'h00B8, 16'h0000, 5'b01010);
    // all select bits set, inward step on track zero
    put_fixed(MODE_CMD_WR, 16'h00DF, 16'h0000, 5'b01010);
    put_fixed(MODE_CMD_WR, 16'h0091, 16'h0000, 5'b01000);
    put_fixed(MODE_STATUS_RD, 16'h0000, 16'h0000, 5'b00010);
    put_fixed(MODE_STATUS_RD, 16'h0000, 16'h0000, 5'b01111);
    put_fixed(MODE_TICK, 16'h0000, 16'h5AA5, 5'b10000);
    // arm and release the mark search
    put_fixed(MODE_CMD_WR, 16'h0111, 16'h0000, 5'b01000);
    put_fixed(MODE_CMD_WR, 16'h0011, 16'h0000, 5'b01000);
    put_fixed(MODE_TICK, 16'h0000, 16'h0000, 5'b01000);
    put_fixed(MODE_TICK, 16'h0000, 16'hFFFF, 5'b11000);
    put_fixed(MODE_TICK, 16'h0000, 16'h1234, 5'b01000);
    put_fixed(MODE_DATA_RD, 16'h0000, 16'h0000, 5'b01000);
    put_fixed(MODE_STATUS_RD, 16'h0000, 16'h0000, 5'b01101);
    // no select bit: side, step and search are ignored
    put_fixed(MODE_CMD_WR, 16'hFFF0, 16'h0000, 5'b01000);
    put_fixed(MODE_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 5'b11111);
    put_fixed(MODE_SPARE_LAST, 16'hFFFF, 16'hFFFF, 5'b11111);
    // write: words into shift and holding, mark, holding overwritten
    put_fixed(MODE_CMD_WR, 16'h0012, 16'h0000, 5'b01000);
    put_fixed(MODE_DATA_WR, 16'hFFFF, 16'h0000, 5'b01000);
    put_fixed(MODE_DATA_WR, 16'h0000, 16'h0000, 5'b01000);
    put_fixed(MODE_CMD_WR, 16'h0212, 16'h0000, 5'b01000);
    put_fixed(MODE_DATA_WR, 16'h1234, 16'h0000, 5'b01000);
    repeat (4) put_fixed(MODE_TICK, 16'h0000, 16'h0000, 5'b01000);
    put_fixed(MODE_DATA_RD, 16'h0000, 16'h0000, 5'b01000);
  endtask

  task read_sector();
    logic [1:0]    drv;
    logic [15:0]   c;
    int unsigned   words;
    ctrl_request_t r;
    drv = 2'($urandom);
    words = $urandom_range(6, 1);
    put_request(sense_req(MODE_CMD_WR, cmd_value(drv, 1'b1, 1'b1, 1'b0)));
    put_request(sense_req(MODE_CMD_WR, cmd_value(drv, 1'b1, 1'b0, 1'b0)));
    repeat ($urandom_range(3, 0)) begin
      r = sense_req(MODE_TICK, 16'($urandom));
      r.mark = 1'b0;
      put_request(r);
    end
    r = sense_req(MODE_TICK, 16'($urandom));
    r.mark = 1'b1;
    r.loaded = 1'b1;
    c = ctrl_scoreboard::crc_next(ctrl_scoreboard::crc_next(CRC_PRESET, r.first_byte),
                                  r.second_byte);
    put_request(r);
    for (int i = 0; i <= words; i++) begin
      if ($urandom_range(5, 0) == 0) put_request(sense_req(MODE_STATUS_RD, 16'($urandom)));
      put_request(sense_req(MODE_DATA_RD, 16'($urandom)));
      r = sense_req(MODE_TICK, 16'($urandom));
      r.loaded = ($urandom_range(31, 0) != 0);
      if (i == words) begin
        r.first_byte = c[15:8];
        r.second_byte = c[7:0];
        if ($urandom_range(3, 0) == 0) r.second_byte = ~r.second_byte;
      end else begin
        c = ctrl_scoreboard::crc_next(ctrl_scoreboard::crc_next(c, r.first_byte),
                                      r.second_byte);
      end
      put_request(r);
    end
    r = sense_req(MODE_TICK, 16'($urandom));
    r.loaded = 1'b1;
    put_request(r);
    put_request(sense_req(MODE_STATUS_RD, 16'($urandom)));
    put_request(sense_req(MODE_DATA_RD, 16'($urandom)));
  endtask

  task write_sector();
    logic [1:0]    drv;
    int unsigned   words;
    ctrl_request_t r;
    drv = 2'($urandom);
    words = $urandom_range(6, 1);
    put_request(sense_req(MODE_CMD_WR, cmd_value(drv, 1'b1, 1'b0, 1'b0)));
    put_request(sense_req(MODE_DATA_WR, 16'($urandom)));
    put_request(sense_req(MODE_DATA_WR, 16'($urandom)));
    put_request(sense_req(MODE_CMD_WR, cmd_value(drv, 1'b1, 1'b0, 1'b1)));
    for (int i = 0; i < words + $urandom_range(3, 2); i++) begin
      r = sense_req(MODE_TICK, 16'($urandom));
      r.loaded = ($urandom_range(7, 0) != 0);
      put_request(r);
      if ($urandom_range(7, 0) == 0) put_request(sense_req(MODE_STATUS_RD, 16'($urandom)));
      if (i < words) begin
        put_request(sense_req(MODE_DATA_WR, 16'($urandom)));
        if ($urandom_range(9, 0) == 0) put_request(sense_req(MODE_DATA_WR, 16'($urandom)));
      end
    end
    if ($urandom_range(1, 0) == 0) put_request(sense_req(MODE_DATA_RD, 16'($urandom)));
  endtask

  task noise_items(int unsigned n);
    repeat (n) put_request(sense_req(3'($urandom), 16'($urandom)));
  endtask

  // result side: own stall pattern plus a long hold-off on demand
  initial begin
    int unsigned style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned cyc;
    style = 0;
    style_left = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(ctrl_result_t'(m_axis_tdata));
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (style_left == 0) begin
        style = $urandom_range(3, 0);
        style_left = $urandom_range(200, 20);
      end
      style_left--;
      cyc++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom);
          2: m_axis_tready <= (cyc % 3 == 0);
          default: m_axis_tready <= ($urandom_range(3, 0) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned phase_end;
    int unsigned pick;
    count_plan = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    for (int p = 0; p <= 8; p++) begin
      drain();
      if (p != 0) write_drive_count(count_plan[p - 1]);
      if (p % 3 == 1) hold_req = 1'b1;
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        pick = $urandom_range(11, 0);
        if (pick < 4) read_sector();
        else if (pick < 7) write_sector();
        else if (pick < 11) noise_items($urandom_range(6, 1));
        else drain();
      end
    end
    drain();
    if (sb.mismatches == 0) begin
      $display("floppy_controller_word_engine_unit test passed");
    end else begin
      $display("floppy_controller_word_engine_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("floppy_controller_word_engine_unit test failed");
    $finish;
  end

endmodule
